### hdl/rbb_pkg.sv
// Shared types and constants for the RGBA 3x3 box blur.
// Used by every module of the block but rbb_ram; depends on nothing.
package rbb_pkg;

   // Default bounds of the image, handed down from the top level
   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Configuration register file
   localparam int WIDTH_REG_W  = 10;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 10'd512;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;
   localparam int MIN_SIZE = 3;

   // Request kinds carried on tuser
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // Pixel layout: red 7:0, green 15:8, blue 23:16, alpha 31:24
   localparam int CH_W  = 8;
   localparam int NUM_CH = 4;
   localparam int PX_W  = CH_W * NUM_CH;

   // Column sum of three samples and window sum of nine
   localparam int CSUM_W = CH_W + 2;
   localparam int TOT_W  = CH_W + 4;

   // Divide by nine: floor(x * 7282 / 2^16) is exact for x below 2304
   localparam int RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = TOT_W + RECIP_W;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // One classified column travelling from front to back
   typedef struct packed {
      logic                              emit;
      logic                              border;
      logic                              last;
      logic [NUM_CH-1:0][CSUM_W-1:0]     csum;
   } rbb_item_type;

endpackage

### hdl/rgba_box_blur_3x3.sv
// Top level of the RGBA 3x3 box blur: configuration registers, front end,
// queue and back end. Uses rbb_pkg, rbb_front, rbb_queue, rbb_back.
//
// Streaming 3x3 mean filter on RGBA pixels sent in raster order, one pixel
// per request. The block takes one request per clock and returns one
// response per clock unless either side stalls; per request the front
// end issues one line-store read and one write, which sets that figure.
// Each channel is the sum of nine neighbors divided by nine, truncated;
// border rows and columns come out as zero. Responses start once image_width+1
// requests are in, and lag the requests by that count plus the pipeline.
// After the last pixel send image_width+1 flush requests (tuser high) to
// drain the image; tlast marks the final response, after which the next
// request starts a new image. Width and height are clamped to 3..MAX_WIDTH
// and 3..MAX_HEIGHT and should be written only while the block is idle.
module rgba_box_blur_3x3 #(
   parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // red_in 7:0, green_in 15:8, blue_in 23:16, alpha_in 31:24
   input  logic [rbb_pkg::PX_W-1:0]        req_tdata,
   // mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // red_out 7:0, green_out 15:8, blue_out 23:16, alpha_out 31:24
   output logic [rbb_pkg::PX_W-1:0]        rsp_tdata,
   output logic                            rsp_tlast
);
   import rbb_pkg::*;

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic                    q_push, q_push_ready, q_valid, q_pop;
   rbb_item_type            q_in_item, q_out_item;

   // Decode configuration writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   rbb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .image_width  (width_ff),
      .image_height (height_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .q_push       (q_push),
      .q_ready      (q_push_ready),
      .q_item       (q_in_item)
   );

   rbb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_push_ready),
      .push_item  (q_in_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_out_item)
   );

   rbb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_item     (q_out_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // The final pixel lies in the corner, so it is always zero
   a_last_is_border: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == '0)
      else $error("last response carries nonzero data");

   // Front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_push_ready)
      else $error("queue push while full");

   // Back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");
`endif

endmodule

### hdl/rbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the two line stores of the blur; no dependencies.
module rbb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rbb_front.sv
// Front end of the blur: accepts requests, tracks image positions, reads
// and rewrites the line stores and pushes column sums. Uses rbb_pkg, rbb_ram.
module rbb_front #(
   parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [rbb_pkg::WIDTH_REG_W-1:0]  image_width,
   input  logic [rbb_pkg::HEIGHT_REG_W-1:0] image_height,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rbb_pkg::PX_W-1:0]         req_tdata,
   input  logic                             req_tuser,
   output logic                             q_push,
   input  logic                             q_ready,
   output rbb_pkg::rbb_item_type            q_item
);
   import rbb_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int CW1 = $clog2(MAX_WIDTH + 1);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int HW1 = $clog2(MAX_HEIGHT + 1);
   localparam logic [1:0] ROW_SAT = 2'd2;

   logic [CW-1:0]  in_col_ff, in_col_in;
   logic [1:0]     in_row_ff, in_row_in;
   logic [CW-1:0]  out_col_ff, out_col_in;
   logic [RW-1:0]  out_row_ff, out_row_in;

   logic            s2_valid_ff, s2_valid_in;
   logic [CW-1:0]   s2_addr_ff;
   logic [PX_W-1:0] s2_px_ff;
   logic            s2_emit_ff, s2_border_ff, s2_last_ff;

   logic [31:0]      w_wide, h_wide;
   logic [CW1-1:0]   w, w_m1, in_col_next, out_col_next;
   logic [HW1-1:0]   h_m1;
   logic [PX_W-1:0]  px;
   logic             accept, advance;
   logic             emit, border, last;
   logic [2*PX_W-1:0] rd_data;

   // Clamp the configured size to the supported range
   always_comb begin
      w_wide = 32'(image_width);
      if (w_wide < 32'(MIN_SIZE)) w_wide = 32'(MIN_SIZE);
      if (w_wide > 32'(MAX_WIDTH)) w_wide = 32'(MAX_WIDTH);
      h_wide = 32'(image_height);
      if (h_wide < 32'(MIN_SIZE)) h_wide = 32'(MIN_SIZE);
      if (h_wide > 32'(MAX_HEIGHT)) h_wide = 32'(MAX_HEIGHT);
      w    = w_wide[CW1-1:0];
      w_m1 = w - 1'b1;
      h_m1 = h_wide[HW1-1:0] - 1'b1;
   end

   // Handshake: take a request whenever the second stage can move on
   assign advance    = s2_valid_ff && q_ready;
   assign req_tready = !s2_valid_ff || q_ready;
   assign accept     = req_tvalid && req_tready;
   assign px         = (req_tuser == MODE_FLUSH) ? '0 : req_tdata;

   // Classify the request from the position counters
   always_comb begin
      emit   = (in_row_ff >= ROW_SAT) || (in_row_ff == 2'd1 && in_col_ff != '0);
      border = (out_row_ff == '0) || (HW1'(out_row_ff) >= h_m1) ||
               (out_col_ff == '0) || (CW1'(out_col_ff) >= w_m1);
      last   = emit && (HW1'(out_row_ff) >= h_m1) && (CW1'(out_col_ff) >= w_m1);
   end

   // Advance the position counters; the last pixel restarts the image
   always_comb begin
      in_col_next  = CW1'(in_col_ff) + 1'b1;
      out_col_next = CW1'(out_col_ff) + 1'b1;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      if (accept) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (emit) begin
               if (out_col_next >= w) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = out_col_next[CW-1:0];
               end
            end
            if (in_col_next >= w) begin
               in_col_in = '0;
               if (in_row_ff != ROW_SAT) in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = in_col_next[CW-1:0];
            end
         end
      end
   end

   assign s2_valid_in = accept || (s2_valid_ff && !q_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Second stage payload: hold while the queue is full
   always_ff @(posedge clock) begin
      if (accept) begin
         s2_addr_ff   <= in_col_ff;
         s2_px_ff     <= px;
         s2_emit_ff   <= emit;
         s2_border_ff <= border;
         s2_last_ff   <= last;
      end
   end

   // Line stores: upper row in the high half, middle row in the low half
   rbb_ram #(
      .WIDTH (2 * PX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s2_addr_ff),
      .wr_data ({rd_data[PX_W-1:0], s2_px_ff}),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (rd_data)
   );

   // Sum the three samples of the column per channel
   always_comb begin
      q_item.emit   = s2_emit_ff;
      q_item.border = s2_border_ff;
      q_item.last   = s2_last_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         q_item.csum[c] = CSUM_W'(rd_data[PX_W + c*CH_W +: CH_W]) +
                          CSUM_W'(rd_data[c*CH_W +: CH_W]) +
                          CSUM_W'(s2_px_ff[c*CH_W +: CH_W]);
      end
   end

   assign q_push = advance;

endmodule

### hdl/rbb_queue.sv
// Short register queue between the front and back of the blur.
// Uses rbb_pkg for the item type and depth.
module rbb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  push_ready,
   input  rbb_pkg::rbb_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop,
   output rbb_pkg::rbb_item_type pop_item
);
   import rbb_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   rbb_item_type    entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != NW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/rbb_back.sv
// Back end of the blur: keeps the window as two column sums, adds the
// nine samples, divides by nine and drives the result channel. Uses rbb_pkg.
module rbb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  rbb_pkg::rbb_item_type     q_item,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [rbb_pkg::PX_W-1:0]  rsp_tdata,
   output logic                      rsp_tlast
);
   import rbb_pkg::*;

   logic [NUM_CH-1:0][CSUM_W-1:0] win0_ff, win0_in, win1_ff, win1_in;
   logic [NUM_CH-1:0][TOT_W-1:0]  total_in, total_ff;
   logic                          b1_valid_ff, b1_valid_in;
   logic                          b1_border_ff, b1_last_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [PX_W-1:0]               out_data_ff, out_data_in;
   logic                          out_last_ff;
   logic                          b1_ready, out_ready;
   logic [PROD_W-1:0]             prod [NUM_CH];

   assign out_ready = !out_valid_ff || rsp_tready;
   assign b1_ready  = !b1_valid_ff || out_ready;
   assign q_pop     = q_valid && b1_ready;

   // Window sum and window shift; the last pixel clears the window
   always_comb begin
      win0_in = win0_ff;
      win1_in = win1_ff;
      for (int c = 0; c < NUM_CH; c++) begin
         total_in[c] = TOT_W'(win0_ff[c]) + TOT_W'(win1_ff[c]) + TOT_W'(q_item.csum[c]);
      end
      if (q_pop) begin
         if (q_item.last) begin
            win0_in = '0;
            win1_in = '0;
         end else begin
            win0_in = win1_ff;
            win1_in = q_item.csum;
         end
      end
      b1_valid_in  = b1_ready ? (q_pop && q_item.emit) : b1_valid_ff;
      out_valid_in = out_ready ? b1_valid_ff : out_valid_ff;
   end

   // Divide by nine through the reciprocal; zero the border
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         prod[c] = PROD_W'(total_ff[c]) * PROD_W'(RECIP_NINE);
         out_data_in[c*CH_W +: CH_W] = b1_border_ff ? '0 : prod[c][RECIP_SHIFT +: CH_W];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff      <= '0;
         win1_ff      <= '0;
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         win0_ff      <= win0_in;
         win1_ff      <= win1_in;
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load when the stage moves on
   always_ff @(posedge clock) begin
      if (q_pop && b1_ready) begin
         total_ff     <= total_in;
         b1_border_ff <= q_item.border;
         b1_last_ff   <= q_item.last;
      end
      if (out_ready && b1_valid_ff) begin
         out_data_ff <= out_data_in;
         out_last_ff <= b1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### tb/rbb_checker.sv
`timescale 1ns / 100ps
// Checker for rgba_box_blur_3x3: follows the register writes, predicts the
// blurred pixel each request produces, if any, and compares it with each response.
// Depends on rbb_pkg.
module rbb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rbb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // red_in 7:0, green_in 15:8, blue_in 23:16, alpha_in 31:24
   input  logic [rbb_pkg::PX_W-1:0]        req_tdata,
   // mode
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // red_out 7:0, green_out 15:8, blue_out 23:16, alpha_out 31:24
   input  logic [rbb_pkg::PX_W-1:0]        rsp_tdata,
   input  logic                            rsp_tlast,
   output int                              mismatch_count,
   output int                              pending_results,
   output int                              frames_predicted,
   output int                              requests_taken
);
   import rbb_pkg::*;

   localparam int WINDOW_PIXELS = 9;

   typedef struct packed {
      logic            last;
      logic [PX_W-1:0] pixel;
   } blur_result_type;

   // Shadow copy of the registers, line stores, window and positions
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   logic [PX_W-1:0]         upper_row [MAX_WIDTH_DEF];
   logic [PX_W-1:0]         middle_row [MAX_WIDTH_DEF];
   logic [PX_W-1:0]         window_cols [2][3];
   int                      in_col, in_row, out_col, out_row;
   blur_result_type         blurred_pixels [$];

   function automatic int clamp_size(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Return to the top left of a fresh image
   task automatic clear_positions();
      int r;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      for (r = 0; r < 3; r++) begin
         window_cols[0][r] = '0;
         window_cols[1][r] = '0;
      end
   endtask

   // Advance the filter by one request; queue the pixel it produces, if any
   task automatic predict_blur_step(input logic mode, input logic [PX_W-1:0] data);
      int w, h, ic, r, c, ch, sum;
      logic [PX_W-1:0] px, mean;
      logic [PX_W-1:0] column [3];
      logic [PX_W-1:0] win [3][3];
      logic emit, border, last;
      blur_result_type res;
      w = clamp_size(int'(width_reg), MIN_SIZE, MAX_WIDTH_DEF);
      h = clamp_size(int'(height_reg), MIN_SIZE, MAX_HEIGHT_DEF);
      // flush requests enter the window as black pixels
      px = (mode == MODE_PIXEL) ? data : '0;
      ic = (in_col >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : in_col;
      column[0] = upper_row[ic];
      column[1] = middle_row[ic];
      column[2] = px;
      upper_row[ic] = column[1];
      middle_row[ic] = px;

      emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
      if (emit) begin
         for (r = 0; r < 3; r++) begin
            win[r][0] = window_cols[0][r];
            win[r][1] = window_cols[1][r];
            win[r][2] = column[r];
         end
         border = out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1;
         last = out_row >= h - 1 && out_col >= w - 1;
         for (ch = 0; ch < NUM_CH; ch++) begin
            sum = 0;
            for (r = 0; r < 3; r++)
               for (c = 0; c < 3; c++)
                  sum += int'(win[r][c][ch*CH_W +: CH_W]);
            mean[ch*CH_W +: CH_W] = border ? '0 : CH_W'(sum / WINDOW_PIXELS);
         end
         res.last = last;
         res.pixel = mean;
         blurred_pixels.push_back(res);
         if (last) begin
            clear_positions();
            frames_predicted++;
            return;
         end
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end

      // shift the window left by one column
      for (r = 0; r < 3; r++) begin
         window_cols[0][r] = window_cols[1][r];
         window_cols[1][r] = column[r];
      end
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
   endtask

   // Follow writes and requests, compare responses in order
   always @(posedge clock) begin
      blur_result_type got, want;
      logic bad;
      int ch;
      if (reset) begin
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         clear_positions();
         blurred_pixels.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_IMAGE_WIDTH)
               width_reg = csr_wdata[WIDTH_REG_W-1:0];
            else
               height_reg = csr_wdata[HEIGHT_REG_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            predict_blur_step(req_tuser, req_tdata);
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.last = rsp_tlast;
            got.pixel = rsp_tdata;
            if (blurred_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: response with nothing pending: last=%0b rgba=%08h",
                           $realtime, got.last, got.pixel);
            end else begin
               want = blurred_pixels.pop_front();
               bad = got.last !== want.last;
               for (ch = 0; ch < NUM_CH; ch++)
                  if (got.pixel[ch*CH_W +: CH_W] !== want.pixel[ch*CH_W +: CH_W])
                     bad = 1'b1;
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: blur mismatch: expected last=%0b rgba=%08h,",
                               " got last=%0b rgba=%08h"},
                              $realtime, want.last, want.pixel, got.last, got.pixel);
               end
            end
         end
      end
      pending_results = blurred_pixels.size();
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the rgba_box_blur_3x3 testbench: clock, reset, register writes and
// pixel requests with random gaps. Depends on rbb_pkg, rbb_checker and the block.
module tb;
   import rbb_pkg::*;

   localparam int RANDOM_ITEMS = 250;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PX_W-1:0]        req_tdata = '0;
   logic                   req_tuser = MODE_PIXEL;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PX_W-1:0]        rsp_tdata;
   logic                   rsp_tlast;

   int mismatch_count, pending_results, frames_predicted, requests_taken;
   bit steady = 1'b0;
   int tready_hold = 0;

   rgba_box_blur_3x3 dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   rbb_checker u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .mismatch_count(mismatch_count), .pending_results(pending_results),
      .frames_predicted(frames_predicted), .requests_taken(requests_taken)
   );

   always #5 clock = ~clock;

   // Mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Random pixel, with black, white and saturated channel mixes now and then
   function automatic logic [PX_W-1:0] random_pixel();
      logic [PX_W-1:0] p;
      int k;
      case ($urandom_range(0, 7))
         0: p = '0;
         1: p = '1;
         2: begin
            for (k = 0; k < NUM_CH; k++)
               p[k*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         default: p = $urandom;
      endcase
      return p;
   endfunction

   // Stall the response side at random, except in steady stretches
   always @(negedge clock) begin
      if (steady) begin
         rsp_tready <= 1'b1;
         tready_hold = 0;
      end else if (tready_hold > 0) begin
         tready_hold--;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         tready_hold = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
         tready_hold = $urandom_range(0, 12);
      end
   end

   // Offer one request after an optional gap; return at the negedge after it is taken
   task automatic send_request(input logic mode, input logic [PX_W-1:0] data);
      int gap, taken;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= mode;
      taken = requests_taken;
      do @(negedge clock); while (requests_taken == taken);
   endtask

   // Hold off requests until every pixel is back and the pipeline is quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] width_val,
                               input logic [CSR_DATA_W-1:0] height_val);
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= width_val;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= height_val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Send the pixels of one image, then flush requests until the last pixel is due
   task automatic send_image(input int pixel_items);
      int frames;
      frames = frames_predicted;
      repeat (pixel_items)
         send_request(($urandom_range(0, 19) == 0) ? MODE_FLUSH : MODE_PIXEL, random_pixel());
      while (frames_predicted == frames)
         send_request(($urandom_range(0, 9) == 0) ? MODE_PIXEL : MODE_FLUSH, random_pixel());
   endtask

   // Overall time limit
   initial begin
      #(20_000_000);
      $display("tb failed");
      $finish;
   end

   initial begin
      int w_val, h_val, img_w, img_h, images, start, k;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // 3x3 image from registers below range; all white gives the largest sum
      set_geometry(13'd0, 13'd2);
      repeat (9) send_request(MODE_PIXEL, '1);
      repeat (4) send_request(MODE_FLUSH, '0);

      // 3x3 ramp with a flush in the middle and a pixel inside the flush
      for (k = 0; k < 9; k++) begin
         if (k == 4)
            send_request(MODE_FLUSH, '1);
         else
            send_request(MODE_PIXEL, {8'(7 * k), 8'(k), 8'(255 - k), 8'(30 * k)});
      end
      send_request(MODE_PIXEL, '1);
      repeat (3) send_request(MODE_FLUSH, 32'h5A5A_A5A5);
      drain_results();

      // widest row, width register all ones; narrow the image past the wrap
      set_geometry(13'h03FF, 13'd3);
      repeat (MAX_WIDTH_DEF + 8) send_request(MODE_PIXEL, random_pixel());
      drain_results();
      set_geometry(13'd5, 13'd3);
      send_image(0);
      drain_results();

      // tall image cut short: lower the height once the output is past the new bound
      set_geometry(13'd5, 13'h1FFF);
      repeat (20) send_request(MODE_PIXEL, random_pixel());
      drain_results();
      set_geometry(13'd5, 13'd3);
      send_image(0);
      drain_results();

      // random geometries, a few images each
      start = requests_taken;
      while (requests_taken - start < RANDOM_ITEMS) begin
         w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
         h_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
         set_geometry({3'($urandom), 10'(w_val)}, 13'(h_val));
         img_w = (w_val < MIN_SIZE) ? MIN_SIZE : w_val;
         img_h = (h_val < MIN_SIZE) ? MIN_SIZE : h_val;
         images = $urandom_range(1, 3);
         repeat (images) begin
            steady = ($urandom_range(0, 4) == 0);
            send_image(img_w * img_h);
         end
         steady = 1'b0;
         drain_results();
      end

      repeat (32) @(negedge clock);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
